[rtl/mssf_pkg.sv]
// Package for the maximal scoring segment finder.
// Holds widths, depths and the stack entry type; no dependencies.
package mssf_pkg;
  localparam int STACK_DEPTH = 32;
  localparam int MAX_LENGTH  = 1048576;
  localparam int SW          = 48;
  localparam int PW          = 21;
  localparam int IW          = $clog2(STACK_DEPTH);
  localparam int CW          = $clog2(STACK_DEPTH + 1);
  localparam int OUT_LIMIT   = 64;
  localparam int OCW         = 7;
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [0:0] CFG_MIN_SCORE  = 1'b0;
  localparam logic [0:0] CFG_DROP_LIMIT = 1'b1;

  typedef struct packed {
    logic [PW-1:0]        start;
    logic [PW-1:0]        stop;
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 has_pre;
    logic [IW-1:0]        pre;
  } entry_t;

  localparam int EW = $bits(entry_t);

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    logic signed [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s[SW] != s[SW-1]) return s[SW] ? SUM_MIN : SUM_MAX;
    return s[SW-1:0];
  endfunction
endpackage

[rtl/mssf_if.sv]
// Valid/ready channel interfaces for the segment finder.
// Depends on mssf_pkg for field widths.
interface mssf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score;
  logic               end_of_sequence;
  modport source (output valid, score, end_of_sequence, input ready);
  modport sink   (input valid, score, end_of_sequence, output ready);
endinterface

interface mssf_out_if;
  logic                        valid;
  logic                        ready;
  logic [mssf_pkg::PW-1:0]     seg_start;
  logic [mssf_pkg::PW-1:0]     seg_end;
  logic [46:0]                 seg_score;
  logic                        last_of_run;
  logic                        stack_overflow;
  modport source (output valid, seg_start, seg_end, seg_score, last_of_run,
                  stack_overflow, input ready);
  modport sink   (input valid, seg_start, seg_end, seg_score, last_of_run,
                  stack_overflow, output ready);
endinterface

[rtl/mssf_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module mssf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/maximal_scoring_segment_finder.sv]
// Top level of the maximal scoring segment finder.
// Depends on mssf_pkg, mssf_if and mssf_ram.
//
// Scores enter on the in channel; each transaction carries one signed score
// and an end-of-sequence mark. Results leave on the out channel, one segment
// per transaction, with last_of_run on the final result of an input item.
// Configuration is to be written by the user on cfg_we/cfg_index/cfg_data
// only while idle; the block itself does not enforce this. The block works
// on one score at a time and takes no new score until it is done with the
// last. Closing a run walks the visited stack entries one by one through the
// single read port (registered read data), then pushes the candidate. A flush
// reads each stacked entry in turn; at end of sequence the open run is closed
// and then the whole stack is flushed. Each found segment is staged one step
// behind the output register so that last_of_run is known before it is shown;
// when the receiver stalls with both full, the sequencer waits.
// Reset clears the position, sums, run state and stack count; the stack RAM
// needs no clearing since only entries below the count are read.
module maximal_scoring_segment_finder (
  input  logic        clk,
  input  logic        rst_n,
  mssf_in_if.sink     in_ch,
  mssf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);
  localparam int SW = mssf_pkg::SW;
  localparam int PW = mssf_pkg::PW;
  localparam int IW = mssf_pkg::IW;
  localparam int CW = mssf_pkg::CW;

  typedef enum logic [3:0] {
    S_IDLE, S_CLOSE, S_WREAD, S_WCHK, S_PUSH, S_DROP, S_EOS, S_FREAD, S_FCHK,
    S_FDONE, S_DONE
  } state_t;

  // What follows a walk or a flush.
  typedef enum logic [1:0] { F_WALK, F_DROP, F_EOS } fret_t;

  state_t state_r;
  fret_t  fret_r;
  logic [30:0] min_score_r, drop_limit_r;
  logic [PW-1:0] pos_r, run_start_r;
  logic signed [SW-1:0] cl_r, rmax_r, run_sum_r;
  logic run_active_r;
  logic [CW-1:0] cnt_r;
  logic signed [15:0] s_r;
  logic eos_r;
  // candidate
  logic [PW-1:0] t_start_r, t_end_r;
  logic signed [SW-1:0] t_left_r, r_r;
  logic [CW-1:0] j_r; // walk index plus one, zero means none
  logic forced_r, pend_r;
  logic [CW-1:0] fi_r;
  logic [mssf_pkg::OCW-1:0] on_r;
  // staged segment
  logic [PW-1:0] p_start_r, p_end_r;
  logic [46:0] p_score_r;
  logic p_ovf_r;
  // output holding
  logic ov_r;
  logic [PW-1:0] o_start_r, o_end_r;
  logic [46:0] o_score_r;
  logic o_last_r, o_ovf_r;

  logic ram_we;
  logic [IW-1:0] ram_wa, ram_ra;
  mssf_pkg::entry_t ram_wd, ram_rd;

  mssf_ram #(.WIDTH(mssf_pkg::EW), .DEPTH(mssf_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.seg_start = o_start_r;
  assign out_ch.seg_end = o_end_r;
  assign out_ch.seg_score = o_score_r;
  assign out_ch.last_of_run = o_last_r;
  assign out_ch.stack_overflow = o_ovf_r;

  logic signed [SW-1:0] s_ext;
  logic signed [SW+1:0] drop_sum, sc_full;
  logic [SW-1:0] sc_clamp;
  logic out_free, seg_pass, mv_go;
  assign s_ext = {{(SW-16){s_r[15]}}, s_r};
  assign drop_sum = {{2{cl_r[SW-1]}}, cl_r} + {{2{s_ext[SW-1]}}, s_ext}
                  + {{(SW-29){1'b0}}, drop_limit_r};
  assign sc_full = {{2{ram_rd.right[SW-1]}}, ram_rd.right}
                 - {{2{ram_rd.left[SW-1]}}, ram_rd.left};
  always_comb begin
    if (sc_full[SW+1]) sc_clamp = '0;
    else if (sc_full[SW:SW-1] != 2'b00) sc_clamp = {1'b0, {(SW-1){1'b1}}};
    else sc_clamp = sc_full[SW-1:0];
  end

  assign out_free = !ov_r || out_ch.ready;
  assign seg_pass = (sc_clamp >= {17'd0, min_score_r})
                  && (on_r < 7'(mssf_pkg::OUT_LIMIT));
  // The staged segment moves out when a newer one replaces it or the item ends.
  assign mv_go = pend_r && out_free
               && ((state_r == S_FCHK && seg_pass) || state_r == S_DONE);

  always_comb begin
    ram_ra = '0;
    if (state_r == S_FREAD || state_r == S_FCHK) ram_ra = fi_r[IW-1:0];
    else ram_ra = j_r[IW-1:0] - 1'b1;
    ram_we = (state_r == S_PUSH);
    ram_wa = cnt_r[IW-1:0];
    ram_wd.start = t_start_r;
    ram_wd.stop = t_end_r;
    ram_wd.left = t_left_r;
    ram_wd.right = r_r;
    ram_wd.has_pre = (j_r != '0);
    ram_wd.pre = j_r[IW-1:0] - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fret_r <= F_WALK;
      min_score_r <= 31'd1;
      drop_limit_r <= '0;
      pos_r <= '0;
      cl_r <= '0;
      rmax_r <= mssf_pkg::SUM_MIN;
      run_active_r <= 1'b0;
      run_start_r <= '0;
      run_sum_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mssf_pkg::CFG_MIN_SCORE) min_score_r <= cfg_data;
        else drop_limit_r <= cfg_data;
      end
      if (mv_go) begin
        ov_r <= 1'b1;
        o_start_r <= p_start_r;
        o_end_r <= p_end_r;
        o_score_r <= p_score_r;
        o_ovf_r <= p_ovf_r;
        o_last_r <= (state_r == S_DONE);
      end else if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          s_r <= in_ch.score;
          eos_r <= in_ch.end_of_sequence;
          on_r <= '0;
          pend_r <= 1'b0;
          state_r <= S_CLOSE;
        end
        S_CLOSE: begin
          if (!s_r[15] && s_r != 16'sd0) begin
            if (!run_active_r) begin
              run_active_r <= 1'b1;
              run_start_r <= pos_r;
              run_sum_r <= s_ext;
            end else run_sum_r <= mssf_pkg::sat_add(run_sum_r, s_ext);
            state_r <= S_EOS;
            if (pos_r < PW'(mssf_pkg::MAX_LENGTH)) pos_r <= pos_r + 1'b1;
          end else if (run_active_r) begin
            r_r <= mssf_pkg::sat_add(cl_r, run_sum_r);
            t_start_r <= run_start_r;
            t_end_r <= pos_r;
            t_left_r <= cl_r;
            if (mssf_pkg::sat_add(cl_r, run_sum_r) > rmax_r)
              rmax_r <= mssf_pkg::sat_add(cl_r, run_sum_r);
            j_r <= cnt_r;
            fret_r <= F_DROP;
            state_r <= S_WREAD;
          end else state_r <= S_DROP;
        end
        S_WREAD: state_r <= S_WCHK;
        S_WCHK: begin
          if (j_r != '0 && !(ram_rd.left < t_left_r)) begin
            if (ram_rd.has_pre && CW'(ram_rd.pre) < j_r - 1'b1)
              j_r <= CW'(ram_rd.pre) + 1'b1;
            else j_r <= j_r - 1'b1;
            state_r <= S_WREAD;
          end else if (j_r != '0 && ram_rd.right < r_r) begin
            t_start_r <= ram_rd.start;
            t_left_r <= ram_rd.left;
            cnt_r <= j_r - 1'b1;
            j_r <= j_r - 1'b1;
            state_r <= S_WREAD;
          end else if (j_r == '0) begin
            rmax_r <= r_r;
            forced_r <= 1'b0;
            fi_r <= '0;
            state_r <= S_FREAD;
          end else if (cnt_r >= CW'(mssf_pkg::STACK_DEPTH)) begin
            j_r <= '0;
            forced_r <= 1'b1;
            fi_r <= '0;
            state_r <= S_FREAD;
          end else state_r <= S_PUSH;
        end
        S_PUSH: begin
          cnt_r <= cnt_r + 1'b1;
          cl_r <= r_r;
          run_active_r <= 1'b0;
          run_sum_r <= '0;
          state_r <= (fret_r == F_DROP) ? S_DROP : S_FDONE;
        end
        S_DROP: begin
          if (drop_limit_r != '0
              && drop_sum < $signed({{2{rmax_r[SW-1]}}, rmax_r})) begin
            cl_r <= s_ext;
            rmax_r <= mssf_pkg::SUM_MIN;
            forced_r <= 1'b0;
            fi_r <= '0;
            fret_r <= F_EOS;
            state_r <= S_FREAD;
          end else begin
            cl_r <= mssf_pkg::sat_add(cl_r, s_ext);
            state_r <= S_EOS;
          end
          if (pos_r < PW'(mssf_pkg::MAX_LENGTH)) pos_r <= pos_r + 1'b1;
        end
        S_EOS: begin
          if (!eos_r) state_r <= S_DONE;
          else if (run_active_r) begin
            r_r <= mssf_pkg::sat_add(cl_r, run_sum_r);
            t_start_r <= run_start_r;
            t_end_r <= pos_r;
            t_left_r <= cl_r;
            if (mssf_pkg::sat_add(cl_r, run_sum_r) > rmax_r)
              rmax_r <= mssf_pkg::sat_add(cl_r, run_sum_r);
            j_r <= cnt_r;
            fret_r <= F_EOS;
            state_r <= S_WREAD;
          end else begin
            forced_r <= 1'b0;
            fi_r <= '0;
            eos_r <= 1'b0;
            fret_r <= F_WALK;
            state_r <= S_FREAD;
          end
        end
        S_FREAD: begin
          if (fi_r >= cnt_r) begin
            cnt_r <= '0;
            if (fret_r == F_WALK) begin
              pos_r <= '0;
              cl_r <= '0;
              rmax_r <= mssf_pkg::SUM_MIN;
              run_active_r <= 1'b0;
              run_start_r <= '0;
              run_sum_r <= '0;
              state_r <= S_DONE;
            end else begin
              // A flush inside the walk still owes the push of the candidate.
              state_r <= run_active_r ? S_PUSH : S_EOS;
            end
          end else state_r <= S_FCHK;
        end
        S_FCHK: begin
          if (!seg_pass) begin
            fi_r <= fi_r + 1'b1;
            state_r <= S_FREAD;
          end else if (!pend_r || out_free) begin
            fi_r <= fi_r + 1'b1;
            p_start_r <= ram_rd.start;
            p_end_r <= ram_rd.stop;
            p_score_r <= sc_clamp[46:0];
            p_ovf_r <= forced_r;
            pend_r <= 1'b1;
            on_r <= on_r + 1'b1;
            state_r <= S_FREAD;
          end
        end
        S_FDONE: state_r <= S_EOS;
        S_DONE: begin
          // The staged segment is the last of this item.
          if (!pend_r) state_r <= S_IDLE;
          else if (out_free) begin
            pend_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !ov_r || o_last_r) else $error("accept while item busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(mssf_pkg::STACK_DEPTH)) else $error("stack count overrun");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r && $stable(o_score_r))
    else $error("result dropped under stall");
endmodule

[test/mssf_segment_scoreboard.sv]
// Watches the score and segment channels of the segment finder, predicts the
// segments each score transaction produces and compares them in order.
// Depends on mssf_pkg and the channel interfaces in mssf_if.
module mssf_segment_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  mssf_in_if          in_ch,
  mssf_out_if         out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  output int          fail_count,
  output int          open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = mssf_pkg::PW;
  localparam int STACK_DEPTH = mssf_pkg::STACK_DEPTH;

  typedef struct {
    logic [PW-1:0] seg_start;
    logic [PW-1:0] seg_end;
    logic [46:0]   seg_score;
    logic          last_of_run;
    logic          stack_overflow;
  } segment_t;

  localparam longint SCORE_MAX = 64'sd140737488355327;
  localparam longint SCORE_MIN = -SCORE_MAX - 1;

  segment_t expected_segs[$];
  segment_t item_segs[$];

  logic [30:0]   min_score_reg;
  logic [30:0]   drop_limit_reg;
  logic [PW-1:0] pos;
  longint        cum_left;
  longint        peak;
  bit            run_open;
  logic [PW-1:0] run_beg;
  longint        run_sum;
  int            depth_used;
  logic [PW-1:0] stk_beg[STACK_DEPTH];
  logic [PW-1:0] stk_end[STACK_DEPTH];
  longint        stk_left[STACK_DEPTH];
  longint        stk_right[STACK_DEPTH];
  int            stk_pre[STACK_DEPTH];

  assign open_count = expected_segs.size();

  function automatic longint sat48(input longint v);
    if (v > SCORE_MAX) return SCORE_MAX;
    if (v < SCORE_MIN) return SCORE_MIN;
    return v;
  endfunction

  task automatic restart_sequence();
    pos = '0;
    cum_left = 0;
    peak = SCORE_MIN;
    run_open = 0;
    run_beg = '0;
    run_sum = 0;
    depth_used = 0;
  endtask

  task automatic report_stack(input bit forced);
    longint   sc;
    segment_t seg;
    for (int i = 0; i < depth_used; i++) begin
      sc = stk_right[i] - stk_left[i];
      if (sc < 0) sc = 0;
      if (sc > SCORE_MAX) sc = SCORE_MAX;
      if (sc >= longint'(min_score_reg) && item_segs.size() < mssf_pkg::OUT_LIMIT) begin
        seg.seg_start = stk_beg[i];
        seg.seg_end = stk_end[i];
        seg.seg_score = sc[46:0];
        seg.last_of_run = 1'b0;
        seg.stack_overflow = forced;
        item_segs.push_back(seg);
      end
    end
    depth_used = 0;
  endtask

  // Walks the stack through predecessor links, merging while the found entry
  // ends lower than the new run, then pushes the candidate.
  task automatic close_run(input logic [PW-1:0] end_pos);
    longint        r;
    logic [PW-1:0] c_beg;
    longint        c_left;
    int            j;
    int            p;
    r = sat48(cum_left + run_sum);
    c_beg = run_beg;
    c_left = cum_left;
    if (r > peak) peak = r;
    forever begin
      j = depth_used - 1;
      while (j >= 0 && stk_left[j] >= c_left) begin
        p = stk_pre[j];
        j = (p >= 0 && p < j) ? p : j - 1;
      end
      if (j >= 0 && stk_right[j] < r) begin
        c_beg = stk_beg[j];
        c_left = stk_left[j];
        depth_used = j;
        continue;
      end
      if (j < 0) begin
        report_stack(1'b0);
        peak = r;
      end else if (depth_used >= STACK_DEPTH) begin
        report_stack(1'b1);
        j = -1;
      end
      stk_beg[depth_used] = c_beg;
      stk_end[depth_used] = end_pos;
      stk_left[depth_used] = c_left;
      stk_right[depth_used] = r;
      stk_pre[depth_used] = j;
      depth_used++;
      break;
    end
    cum_left = r;
    run_open = 0;
    run_sum = 0;
  endtask

  task automatic predict_score(input logic signed [15:0] score, input logic eos);
    longint s;
    s = longint'(score);
    item_segs.delete();
    if (s > 0) begin
      if (!run_open) begin
        run_open = 1;
        run_beg = pos;
        run_sum = 0;
      end
      run_sum = sat48(run_sum + s);
    end else begin
      if (run_open) close_run(pos);
      if (drop_limit_reg != 0 && cum_left + s + longint'(drop_limit_reg) < peak) begin
        report_stack(1'b0);
        cum_left = 0;
        peak = SCORE_MIN;
      end
      cum_left = sat48(cum_left + s);
    end
    if (pos < PW'(mssf_pkg::MAX_LENGTH)) pos = pos + 1'b1;
    if (eos) begin
      if (run_open) close_run(pos);
      report_stack(1'b0);
      restart_sequence();
    end
    if (item_segs.size() > 0) item_segs[$].last_of_run = 1'b1;
    foreach (item_segs[k]) expected_segs.push_back(item_segs[k]);
  endtask

  task automatic compare_segment();
    segment_t want;
    if (expected_segs.size() == 0) begin
      $error("unexpected segment transaction: start %0d end %0d score %0d",
             out_ch.seg_start, out_ch.seg_end, out_ch.seg_score);
      fail_count++;
      return;
    end
    want = expected_segs.pop_front();
    if (out_ch.seg_start !== want.seg_start) begin
      $error("seg_start expected %0d actual %0d", want.seg_start, out_ch.seg_start);
      fail_count++;
    end
    if (out_ch.seg_end !== want.seg_end) begin
      $error("seg_end expected %0d actual %0d", want.seg_end, out_ch.seg_end);
      fail_count++;
    end
    if (out_ch.seg_score !== want.seg_score) begin
      $error("seg_score expected %0d actual %0d", want.seg_score, out_ch.seg_score);
      fail_count++;
    end
    if (out_ch.last_of_run !== want.last_of_run) begin
      $error("last_of_run expected %0d actual %0d", want.last_of_run,
             out_ch.last_of_run);
      fail_count++;
    end
    if (out_ch.stack_overflow !== want.stack_overflow) begin
      $error("stack_overflow expected %0d actual %0d", want.stack_overflow,
             out_ch.stack_overflow);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      min_score_reg = 31'd1;
      drop_limit_reg = '0;
      restart_sequence();
      expected_segs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == mssf_pkg::CFG_MIN_SCORE) min_score_reg = cfg_data;
        else drop_limit_reg = cfg_data;
      end
      if (out_ch.valid && out_ch.ready) compare_segment();
      if (in_ch.valid && in_ch.ready) predict_score(in_ch.score, in_ch.end_of_sequence);
    end
  end
endmodule

[test/tb_top.sv]
// Top of the segment finder testbench: clock, reset, score stimulus, register
// writes and the verdict. Depends on mssf_pkg, mssf_if and the scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int QUIET_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = mssf_pkg::CFG_MIN_SCORE;
  logic [30:0] cfg_data = '0;
  int          fail_count;
  int          open_count;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  int          scores_sent = 0;

  mssf_in_if  in_ch ();
  mssf_out_if out_ch ();

  always #5 clk = ~clk;

  maximal_scoring_segment_finder dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mssf_segment_scoreboard scoreboard (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .open_count(open_count)
  );

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[maximal_scoring_segment_finder] ERROR");
      $finish;
    end
  end

  // Valid stays high from one transaction to the next unless the sender idles.
  task automatic send_score(input logic signed [15:0] score, input logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.score <= score;
    in_ch.end_of_sequence <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scores_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0 || !in_ch.ready) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_score();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'sd32767;
      2: return -16'sd32768;
      3: return 16'sd0;
      default: return 16'(int'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic random_sequence(input int len, input bit closed);
    for (int i = 0; i < len; i++) send_score(pick_score(), closed && i == len - 1);
  endtask

  // Each pair drops below the last right value and climbs back to one less than
  // it, so the runs nest and pile up on the stack; long ones overflow it.
  task automatic nested_sequence(input int pairs);
    int p;
    send_score(16'sd20000, 1'b0);
    for (int i = 0; i < pairs; i++) begin
      p = $urandom_range(1, 60);
      send_score(16'(-(p + 1)), 1'b0);
      send_score(16'(p), i == pairs - 1 && $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic random_config();
    case ($urandom_range(0, 3))
      0: write_reg(mssf_pkg::CFG_MIN_SCORE, 31'd0);
      1: write_reg(mssf_pkg::CFG_MIN_SCORE, 31'($urandom_range(1, 300)));
      2: write_reg(mssf_pkg::CFG_MIN_SCORE, 31'h7fffffff);
      default: write_reg(mssf_pkg::CFG_MIN_SCORE, 31'd1);
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(mssf_pkg::CFG_DROP_LIMIT, 31'd0);
      1: write_reg(mssf_pkg::CFG_DROP_LIMIT, 31'($urandom_range(1, 2000)));
      2: write_reg(mssf_pkg::CFG_DROP_LIMIT, 31'h7fffffff);
      default: write_reg(mssf_pkg::CFG_DROP_LIMIT, 31'($urandom));
    endcase
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.score = '0;
    in_ch.end_of_sequence = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first under reset settings and then under written ones.
    send_score(16'sd32767, 1'b0);
    send_score(-16'sd32768, 1'b0);
    send_score(16'sd1, 1'b0);
    send_score(16'sd0, 1'b0);
    send_score(16'sd5, 1'b0);
    send_score(-16'sd1, 1'b0);
    send_score(16'sd7, 1'b1);
    send_score(-16'sd3, 1'b1);
    send_score(16'sd0, 1'b1);
    send_score(16'sd32767, 1'b1);
    write_reg(mssf_pkg::CFG_MIN_SCORE, 31'd0);
    write_reg(mssf_pkg::CFG_DROP_LIMIT, 31'd1);
    send_score(16'sd10, 1'b0);
    send_score(-16'sd5, 1'b0);
    send_score(16'sd2, 1'b0);
    send_score(-16'sd1, 1'b1);
    write_reg(mssf_pkg::CFG_MIN_SCORE, 31'h7fffffff);
    write_reg(mssf_pkg::CFG_DROP_LIMIT, 31'h7fffffff);
    send_score(16'sd300, 1'b0);
    send_score(-16'sd32768, 1'b0);
    send_score(16'sd4, 1'b1);
    write_reg(mssf_pkg::CFG_MIN_SCORE, 31'd1);
    write_reg(mssf_pkg::CFG_DROP_LIMIT, 31'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      if (phase != 0) random_config();
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 3) == 0) nested_sequence($urandom_range(3, 20));
        else random_sequence($urandom_range(1, 12), $urandom_range(0, 5) != 0);
      end
      if (phase == 1) drain();
    end
    // A final nested run deep enough to overflow the stack.
    nested_sequence(mssf_pkg::STACK_DEPTH + 4);
    send_score(-16'sd1, 1'b1);

    drain();
    if (fail_count == 0) begin
      $display("[maximal_scoring_segment_finder] OK");
    end else begin
      $display("[maximal_scoring_segment_finder] ERROR");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/mssf_pkg.sv
rtl/mssf_if.sv
rtl/mssf_ram.sv
rtl/maximal_scoring_segment_finder.sv
test/mssf_segment_scoreboard.sv
test/tb_top.sv
